// ===== hdl/gsm_pkg.sv =====
// ---------------------------------------------------------------------------
// gsm_pkg
// Shared widths, codes and record types of the graph segment merge core.
// ---------------------------------------------------------------------------
package gsm_pkg;

    localparam int VERT_W   = 10;
    localparam int WEIGHT_W = 16;
    localparam int THR_W    = 18;
    localparam int SIZE_W   = 11;
    localparam int COUNT_W  = 11;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_LABEL = 1'b1;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_VERTEX    = 1'b1;

    localparam logic [WEIGHT_W-1:0] THRESHOLD_RESET = 16'd256;
    localparam logic [COUNT_W-1:0]  VERTEX_RESET    = 11'd1024;

    typedef struct packed {
        logic [VERT_W-1:0]   a;
        logic [VERT_W-1:0]   b;
        logic [WEIGHT_W-1:0] w;
    } edge_rec_t;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [THR_W-1:0]  thr;
    } set_ent_t;

endpackage

// ===== hdl/gsm_div.sv =====
// ---------------------------------------------------------------------------
// gsm_div
// Restoring divider: merge constant over set size, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module gsm_div
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gsm_pkg::WEIGHT_W-1:0] dividend,
    input  logic [gsm_pkg::SIZE_W-1:0]   divisor,
    output logic                         done,
    output logic [gsm_pkg::WEIGHT_W-1:0] quotient
);

    localparam int CNT_W = $clog2(gsm_pkg::WEIGHT_W + 1);

    logic                         busy_reg;
    logic                         done_reg;
    logic [CNT_W-1:0]             cnt_reg;
    logic [gsm_pkg::SIZE_W-1:0]   rem_reg;
    logic [gsm_pkg::WEIGHT_W-1:0] quo_reg;
    logic [gsm_pkg::SIZE_W-1:0]   dvs_reg;
    logic [gsm_pkg::SIZE_W:0]     trial;
    logic                         fits;

    assign trial = {rem_reg, quo_reg[gsm_pkg::WEIGHT_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(gsm_pkg::WEIGHT_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? gsm_pkg::SIZE_W'(trial - {1'b0, dvs_reg})
                            : trial[gsm_pkg::SIZE_W-1:0];
            quo_reg <= {quo_reg[gsm_pkg::WEIGHT_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/graph_segment_merge_core.sv =====
// ---------------------------------------------------------------------------
// graph_segment_merge_core
// Greedy graph segmentation: edge store, radix sort, union walk, label query.
// ---------------------------------------------------------------------------
// An edge load is written to the edge store as it is accepted. A label query
// reads and checks each step up the parent chain of the vertex (S_FIND_RD,
// S_FIND_CHK). The load marked last starts a run of set initialization over
// MAX_VERTICES entries, 16 one-bit stable radix passes over the stored edges
// (each edge record read, then written), per edge both finds, then the set
// lookup (S_SET_RD_A, S_SET_RD_B, S_SET_CHK) and the serial divider on a
// merge, and finally a read and a check per vertex in use to count roots.
// After reset the block initializes all MAX_VERTICES vertex sets and
// accepts no transaction meanwhile; configuration writes are taken always.
// ---------------------------------------------------------------------------
module graph_segment_merge_core #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 4096
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                cmd,
    input  logic [gsm_pkg::VERT_W-1:0]          vertex_a,
    input  logic [gsm_pkg::VERT_W-1:0]          vertex_b,
    input  logic [gsm_pkg::WEIGHT_W-1:0]        weight,
    input  logic                                last,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                kind,
    output logic [gsm_pkg::COUNT_W-1:0]         segment_count,
    output logic [gsm_pkg::VERT_W-1:0]          label,
    output logic                                overflow,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int VW = $clog2(MAX_VERTICES);
    localparam int EW = $clog2(MAX_EDGES);
    localparam int PW = (VW > gsm_pkg::VERT_W) ? VW : gsm_pkg::VERT_W;
    localparam int CW = (VW + 1 > gsm_pkg::COUNT_W) ? VW + 1 : gsm_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SORT_RD, S_SORT_WR, S_WALK_RD, S_WALK_GET,
        S_FIND_RD, S_FIND_CHK, S_SET_RD_A, S_SET_RD_B, S_SET_CHK, S_DIV,
        S_CNT_RD, S_CNT_CHK
    } state_t;

    typedef enum logic [1:0] {FIND_A, FIND_B, FIND_Q} find_sel_t;

    logic [gsm_pkg::WEIGHT_W-1:0] k_reg;
    logic [gsm_pkg::COUNT_W-1:0]  vcount_reg;
    logic [gsm_pkg::COUNT_W-1:0]  nv;

    state_t                       state_reg, state_next;
    logic [VW:0]                  vidx_reg, vidx_next;
    logic [EW:0]                  idx_reg, idx_next;
    logic [3:0]                   pass_reg, pass_next;
    logic [EW:0]                  zpos_reg, zpos_next;
    logic [EW:0]                  opos_reg, opos_next;
    logic [EW:0]                  fill_reg, fill_next;
    logic                         dropped_reg, dropped_next;
    logic                         run_pending_reg, run_pending_next;
    logic [EW:0]                  ones_reg [gsm_pkg::WEIGHT_W];
    logic [EW:0]                  ones_next [gsm_pkg::WEIGHT_W];
    find_sel_t                    find_sel_reg, find_sel_next;
    logic [PW-1:0]                find_v_reg, find_v_next;
    logic [PW-1:0]                ra_reg, ra_next;
    logic [PW-1:0]                rb_reg, rb_next;
    logic [PW-1:0]                root_reg, root_next;
    gsm_pkg::set_ent_t            set_a_reg, set_a_next;
    logic [gsm_pkg::SIZE_W-1:0]   size_sum_reg, size_sum_next;
    gsm_pkg::edge_rec_t           rec_reg, rec_next;
    logic [gsm_pkg::COUNT_W-1:0]  count_reg, count_next;

    logic                         result_valid_reg, result_valid_next;
    logic                         kind_reg, kind_next;
    logic [gsm_pkg::COUNT_W-1:0]  segment_count_reg, segment_count_next;
    logic [gsm_pkg::VERT_W-1:0]   label_reg, label_next;
    logic                         overflow_reg, overflow_next;

    logic [PW-1:0]                parent_mem [MAX_VERTICES];
    logic                         p_we;
    logic [VW-1:0]                p_waddr, p_raddr;
    logic [PW-1:0]                p_wdata, p_rdata_reg;

    gsm_pkg::set_ent_t            set_mem [MAX_VERTICES];
    logic                         s_we;
    logic [VW-1:0]                s_waddr, s_raddr;
    gsm_pkg::set_ent_t            s_wdata, s_rdata_reg;

    gsm_pkg::edge_rec_t           bank_a_mem [MAX_EDGES];
    gsm_pkg::edge_rec_t           bank_b_mem [MAX_EDGES];
    logic                         a_we, b_we;
    logic [EW-1:0]                a_waddr, b_waddr;
    gsm_pkg::edge_rec_t           a_wdata, b_wdata;
    gsm_pkg::edge_rec_t           a_rdata_reg, b_rdata_reg;

    logic                         div_start;
    logic                         div_done;
    logic [gsm_pkg::SIZE_W-1:0]   div_divisor;
    logic [gsm_pkg::WEIGHT_W-1:0] div_quotient;

    logic                         accept;

    gsm_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (k_reg),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg      <= gsm_pkg::THRESHOLD_RESET;
            vcount_reg <= gsm_pkg::VERTEX_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                gsm_pkg::REG_THRESHOLD: k_reg      <= pwdata[gsm_pkg::WEIGHT_W-1:0];
                gsm_pkg::REG_VERTEX:    vcount_reg <= pwdata[gsm_pkg::COUNT_W-1:0];
                default:                k_reg      <= k_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            gsm_pkg::REG_THRESHOLD: prdata = 32'(k_reg);
            gsm_pkg::REG_VERTEX:    prdata = 32'(vcount_reg);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign nv = (32'(vcount_reg) > MAX_VERTICES) ? gsm_pkg::COUNT_W'(MAX_VERTICES)
                                                 : vcount_reg;

    assign item_stall = (state_reg != S_IDLE) || (result_valid_reg && result_stall);
    assign accept     = item_valid && !item_stall;

    // memories
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
        p_rdata_reg <= parent_mem[p_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            set_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= set_mem[s_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            bank_a_mem[a_waddr] <= a_wdata;
        end
        a_rdata_reg <= bank_a_mem[idx_reg[EW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            bank_b_mem[b_waddr] <= b_wdata;
        end
        b_rdata_reg <= bank_b_mem[idx_reg[EW-1:0]];
    end

    // sequencer
    always_comb
    begin
        gsm_pkg::edge_rec_t  rec;
        gsm_pkg::set_ent_t   set_b;
        logic [PW-1:0]       other;
        logic [gsm_pkg::SIZE_W-1:0] sum;

        rec   = pass_reg[0] ? b_rdata_reg : a_rdata_reg;
        set_b = s_rdata_reg;
        sum   = set_a_reg.size + set_b.size;
        other = ra_reg;

        state_next         = state_reg;
        vidx_next          = vidx_reg;
        idx_next           = idx_reg;
        pass_next          = pass_reg;
        zpos_next          = zpos_reg;
        opos_next          = opos_reg;
        fill_next          = fill_reg;
        dropped_next       = dropped_reg;
        run_pending_next   = run_pending_reg;
        ones_next          = ones_reg;
        find_sel_next      = find_sel_reg;
        find_v_next        = find_v_reg;
        ra_next            = ra_reg;
        rb_next            = rb_reg;
        root_next          = root_reg;
        set_a_next         = set_a_reg;
        size_sum_next      = size_sum_reg;
        rec_next           = rec_reg;
        count_next         = count_reg;
        result_valid_next  = result_valid_reg;
        kind_next          = kind_reg;
        segment_count_next = segment_count_reg;
        label_next         = label_reg;
        overflow_next      = overflow_reg;

        p_we        = 1'b0;
        p_waddr     = VW'(vidx_reg);
        p_wdata     = PW'(vidx_reg);
        p_raddr     = VW'(find_v_reg);
        s_we        = 1'b0;
        s_waddr     = VW'(vidx_reg);
        s_wdata     = '{size: gsm_pkg::SIZE_W'(1), thr: gsm_pkg::THR_W'(k_reg)};
        s_raddr     = VW'(ra_reg);
        a_we        = 1'b0;
        a_waddr     = fill_reg[EW-1:0];
        a_wdata     = '{a: vertex_a, b: vertex_b, w: weight};
        b_we        = 1'b0;
        b_waddr     = zpos_reg[EW-1:0];
        b_wdata     = rec;
        div_start   = 1'b0;
        div_divisor = sum;

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                p_we = 1'b1;
                s_we = 1'b1;
                if (vidx_reg == (VW + 1)'(MAX_VERTICES - 1))
                begin
                    vidx_next = '0;
                    if (run_pending_reg)
                    begin
                        run_pending_next = 1'b0;
                        pass_next        = '0;
                        idx_next         = '0;
                        zpos_next        = '0;
                        opos_next        = fill_reg - ones_reg[0];
                        state_next       = S_SORT_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    vidx_next = vidx_reg + (VW + 1)'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == gsm_pkg::CMD_QUERY)
                    begin
                        if (32'(vertex_a) >= MAX_VERTICES)
                        begin
                            result_valid_next  = 1'b1;
                            kind_next          = gsm_pkg::KIND_LABEL;
                            segment_count_next = '0;
                            label_next         = vertex_a;
                            overflow_next      = 1'b0;
                        end
                        else
                        begin
                            find_v_next   = PW'(vertex_a);
                            find_sel_next = FIND_Q;
                            state_next    = S_FIND_RD;
                        end
                    end
                    else
                    begin
                        if (32'(fill_reg) < MAX_EDGES)
                        begin
                            a_we      = 1'b1;
                            fill_next = fill_reg + (EW + 1)'(1);
                            for (int j = 0; j < gsm_pkg::WEIGHT_W; j++)
                            begin
                                ones_next[j] = ones_reg[j] + (EW + 1)'(weight[j]);
                            end
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                        if (last)
                        begin
                            run_pending_next = 1'b1;
                            vidx_next        = '0;
                            state_next       = S_INIT;
                        end
                    end
                end
            end

            S_SORT_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    idx_next = '0;
                    if (pass_reg == 4'(gsm_pkg::WEIGHT_W - 1))
                    begin
                        state_next = S_WALK_RD;
                    end
                    else
                    begin
                        pass_next = pass_reg + 4'd1;
                        zpos_next = '0;
                        opos_next = fill_reg - ones_reg[pass_reg + 4'd1];
                    end
                end
                else
                begin
                    state_next = S_SORT_WR;
                end
            end

            S_SORT_WR:
            begin
                if (rec.w[pass_reg])
                begin
                    a_waddr   = opos_reg[EW-1:0];
                    b_waddr   = opos_reg[EW-1:0];
                    opos_next = opos_reg + (EW + 1)'(1);
                end
                else
                begin
                    a_waddr   = zpos_reg[EW-1:0];
                    b_waddr   = zpos_reg[EW-1:0];
                    zpos_next = zpos_reg + (EW + 1)'(1);
                end
                a_wdata    = rec;
                a_we       = pass_reg[0];
                b_we       = !pass_reg[0];
                idx_next   = idx_reg + (EW + 1)'(1);
                state_next = S_SORT_RD;
            end

            S_WALK_RD:
            begin
                if (idx_reg == fill_reg)
                begin
                    vidx_next  = '0;
                    count_next = '0;
                    state_next = S_CNT_RD;
                end
                else
                begin
                    state_next = S_WALK_GET;
                end
            end

            S_WALK_GET:
            begin
                rec_next = a_rdata_reg;
                if (({1'b0, a_rdata_reg.a} >= nv) || ({1'b0, a_rdata_reg.b} >= nv))
                begin
                    idx_next   = idx_reg + (EW + 1)'(1);
                    state_next = S_WALK_RD;
                end
                else
                begin
                    find_v_next   = PW'(a_rdata_reg.a);
                    find_sel_next = FIND_A;
                    state_next    = S_FIND_RD;
                end
            end

            S_FIND_RD:
            begin
                state_next = S_FIND_CHK;
            end

            S_FIND_CHK:
            begin
                if (p_rdata_reg == find_v_reg)
                begin
                    case (find_sel_reg)
                        FIND_A:
                        begin
                            ra_next       = find_v_reg;
                            find_v_next   = PW'(rec_reg.b);
                            find_sel_next = FIND_B;
                            state_next    = S_FIND_RD;
                        end
                        FIND_B:
                        begin
                            rb_next = find_v_reg;
                            if (ra_reg == find_v_reg)
                            begin
                                idx_next   = idx_reg + (EW + 1)'(1);
                                state_next = S_WALK_RD;
                            end
                            else
                            begin
                                state_next = S_SET_RD_A;
                            end
                        end
                        FIND_Q:
                        begin
                            result_valid_next  = 1'b1;
                            kind_next          = gsm_pkg::KIND_LABEL;
                            segment_count_next = '0;
                            label_next         = find_v_reg[gsm_pkg::VERT_W-1:0];
                            overflow_next      = 1'b0;
                            state_next         = S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
                else
                begin
                    find_v_next = p_rdata_reg;
                    state_next  = S_FIND_RD;
                end
            end

            S_SET_RD_A:
            begin
                s_raddr    = VW'(ra_reg);
                state_next = S_SET_RD_B;
            end

            S_SET_RD_B:
            begin
                s_raddr    = VW'(rb_reg);
                set_a_next = s_rdata_reg;
                state_next = S_SET_CHK;
            end

            S_SET_CHK:
            begin
                if ((gsm_pkg::THR_W'(rec_reg.w) > set_a_reg.thr)
                    || (gsm_pkg::THR_W'(rec_reg.w) > set_b.thr))
                begin
                    idx_next   = idx_reg + (EW + 1)'(1);
                    state_next = S_WALK_RD;
                end
                else
                begin
                    if (set_b.size > set_a_reg.size)
                    begin
                        root_next = rb_reg;
                        other     = ra_reg;
                    end
                    else
                    begin
                        root_next = ra_reg;
                        other     = rb_reg;
                    end
                    p_we          = 1'b1;
                    p_waddr       = VW'(other);
                    p_wdata       = root_next;
                    size_sum_next = sum;
                    div_start     = 1'b1;
                    state_next    = S_DIV;
                end
            end

            S_DIV:
            begin
                if (div_done)
                begin
                    s_we       = 1'b1;
                    s_waddr    = VW'(root_reg);
                    s_wdata    = '{size: size_sum_reg,
                                   thr: gsm_pkg::THR_W'(rec_reg.w)
                                        + gsm_pkg::THR_W'(div_quotient)};
                    idx_next   = idx_reg + (EW + 1)'(1);
                    state_next = S_WALK_RD;
                end
            end

            S_CNT_RD:
            begin
                p_raddr = VW'(vidx_reg);
                if (CW'(vidx_reg) >= CW'(nv))
                begin
                    result_valid_next  = 1'b1;
                    kind_next          = gsm_pkg::KIND_RUN;
                    segment_count_next = count_reg;
                    label_next         = '0;
                    overflow_next      = dropped_reg;
                    fill_next          = '0;
                    dropped_next       = 1'b0;
                    for (int j = 0; j < gsm_pkg::WEIGHT_W; j++)
                    begin
                        ones_next[j] = '0;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_CNT_CHK;
                end
            end

            S_CNT_CHK:
            begin
                if (p_rdata_reg == PW'(vidx_reg))
                begin
                    count_next = count_reg + gsm_pkg::COUNT_W'(1);
                end
                vidx_next  = vidx_reg + (VW + 1)'(1);
                state_next = S_CNT_RD;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_INIT;
            vidx_reg         <= '0;
            idx_reg          <= '0;
            pass_reg         <= '0;
            fill_reg         <= '0;
            dropped_reg      <= 1'b0;
            run_pending_reg  <= 1'b0;
            find_sel_reg     <= FIND_A;
            result_valid_reg <= 1'b0;
            for (int j = 0; j < gsm_pkg::WEIGHT_W; j++)
            begin
                ones_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            vidx_reg         <= vidx_next;
            idx_reg          <= idx_next;
            pass_reg         <= pass_next;
            fill_reg         <= fill_next;
            dropped_reg      <= dropped_next;
            run_pending_reg  <= run_pending_next;
            find_sel_reg     <= find_sel_next;
            result_valid_reg <= result_valid_next;
            ones_reg         <= ones_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zpos_reg          <= zpos_next;
        opos_reg          <= opos_next;
        find_v_reg        <= find_v_next;
        ra_reg            <= ra_next;
        rb_reg            <= rb_next;
        root_reg          <= root_next;
        set_a_reg         <= set_a_next;
        size_sum_reg      <= size_sum_next;
        rec_reg           <= rec_next;
        count_reg         <= count_next;
        kind_reg          <= kind_next;
        segment_count_reg <= segment_count_next;
        label_reg         <= label_next;
        overflow_reg      <= overflow_next;
    end

    assign result_valid  = result_valid_reg;
    assign kind          = kind_reg;
    assign segment_count = segment_count_reg;
    assign label         = label_reg;
    assign overflow      = overflow_reg;

endmodule
